@@ hdl/cfc_pkg.sv @@
// shared constants and types for the command frame checker
`default_nettype none

package cfc_pkg;

    localparam logic [7:0]  FRAME_START   = 8'h7E;
    localparam logic [7:0]  FRAME_VERSION = 8'hFF;
    localparam logic [7:0]  FRAME_LENGTH  = 8'h06;
    localparam logic [7:0]  FRAME_END     = 8'hEF;
    localparam logic [3:0]  LAST_POS      = 4'd9;

    // positions within a frame
    localparam logic [3:0]  POS_START   = 4'd0;
    localparam logic [3:0]  POS_VERSION = 4'd1;
    localparam logic [3:0]  POS_LENGTH  = 4'd2;
    localparam logic [3:0]  POS_COMMAND = 4'd3;
    localparam logic [3:0]  POS_FEEDBK  = 4'd4;
    localparam logic [3:0]  POS_PARAM_H = 4'd5;
    localparam logic [3:0]  POS_PARAM_L = 4'd6;
    localparam logic [3:0]  POS_CK_HI   = 4'd7;
    localparam logic [3:0]  POS_CK_LO   = 4'd8;

    // status codes
    localparam logic [2:0]  ST_OK      = 3'd0;
    localparam logic [2:0]  ST_START   = 3'd1;
    localparam logic [2:0]  ST_VERSION = 3'd2;
    localparam logic [2:0]  ST_LENGTH  = 3'd3;
    localparam logic [2:0]  ST_CKHI    = 3'd4;
    localparam logic [2:0]  ST_CKLO    = 3'd5;
    localparam logic [2:0]  ST_END     = 3'd6;

    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] param;
        logic [2:0]  status;
    } t_frame_result;

endpackage

`default_nettype wire

@@ hdl/cfc_frame.sv @@
// frame position counter, running sum and first-error tracking
`default_nettype none

module cfc_frame
    import cfc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [7:0]    i_byte,
    output logic               o_last,
    output t_frame_result      o_result
);

    logic [3:0]  r_pos,   n_pos;
    logic [10:0] r_sum,   n_sum;
    logic [2:0]  r_err,   n_err;
    logic [7:0]  r_cmd,   n_cmd;
    logic [15:0] r_param, n_param;

    logic [15:0] ck;
    logic        bad;
    logic [2:0]  code;
    logic        header_bad;

    // two's complement of the running sum, 16 bits
    assign ck     = 16'(~{5'd0, r_sum} + 16'd1);
    assign o_last = (r_pos >= LAST_POS);

    always_comb begin
        bad  = 1'b0;
        code = ST_OK;
        n_cmd   = r_cmd;
        n_param = r_param;
        n_sum   = r_sum;
        if (r_pos >= POS_VERSION && r_pos <= POS_PARAM_L) begin
            n_sum = r_sum + {3'd0, i_byte};
        end
        unique case (r_pos)
            POS_START: begin
                bad  = (i_byte != FRAME_START);
                code = ST_START;
            end
            POS_VERSION: begin
                bad  = (i_byte != FRAME_VERSION);
                code = ST_VERSION;
            end
            POS_LENGTH: begin
                bad  = (i_byte != FRAME_LENGTH);
                code = ST_LENGTH;
            end
            POS_COMMAND: n_cmd = i_byte;
            POS_FEEDBK:  ;
            POS_PARAM_H: n_param = {i_byte, r_param[7:0]};
            POS_PARAM_L: n_param = {r_param[15:8], i_byte};
            POS_CK_HI: begin
                bad  = (i_byte != ck[15:8]);
                code = ST_CKHI;
            end
            POS_CK_LO: begin
                bad  = (i_byte != ck[7:0]);
                code = ST_CKLO;
            end
            default: begin
                bad  = (i_byte != FRAME_END);
                code = ST_END;
            end
        endcase

        n_err = (bad && r_err == ST_OK) ? code : r_err;

        header_bad = (n_err == ST_START) || (n_err == ST_VERSION) || (n_err == ST_LENGTH);
        o_result.status  = n_err;
        o_result.command = header_bad ? 8'd0 : r_cmd;
        o_result.param   = (n_err == ST_OK) ? r_param : 16'd0;

        n_pos = r_pos + 4'd1;
        if (o_last) begin
            n_pos   = 4'd0;
            n_sum   = 11'd0;
            n_err   = ST_OK;
            n_cmd   = 8'd0;
            n_param = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 4'd0;
            r_sum   <= 11'd0;
            r_err   <= ST_OK;
            r_cmd   <= 8'd0;
            r_param <= 16'd0;
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_err   <= n_err;
            r_cmd   <= n_cmd;
            r_param <= n_param;
        end
    end

endmodule

`default_nettype wire

@@ hdl/command_frame_checker.sv @@
// top level: ten-byte command frame checker with input and result registers
//
// input channel: one received byte per word on i_rx_byte, valid/ready handshake
// bytes are grouped into ten-byte frames purely by counting, never realigned
// each frame is checked for start, version, length, checksum and end bytes
// result channel: one word per frame with command, param and status
// status reports the first failing check in byte order, 0 when the frame is good
// command reads 0 after a header failure, param reads 0 after any failure
// throughput: one byte per cycle while the result slot is free, set by the single
// frame update stage; the result is valid in the cycle after the tenth byte leaves
// the input register, which takes each byte as it is accepted
// receiver stall: the result is held in the output register; bytes one to nine
// of the next frame keep flowing, only the tenth waits for the register to free
// reset: synchronous active-low, empties both registers and starts a new frame
`default_nettype none

module command_frame_checker
    import cfc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_command,
    output logic [15:0]        o_param,
    output logic [2:0]         o_status
);

    // input register
    logic          r_in_vld;
    logic [7:0]    r_in_byte;

    // result register
    logic          r_out_vld;
    t_frame_result r_out;

    logic          last;
    logic          adv;
    logic          out_free;
    t_frame_result frame_res;

    cfc_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_byte   (r_in_byte),
        .o_last   (last),
        .o_result (frame_res)
    );

    // the last byte of a frame only moves on when the result slot is free
    assign out_free   = !r_out_vld || i_out_ready;
    assign adv        = r_in_vld && (!last || out_free);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && last) begin
            r_out <= frame_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_command   = r_out.command;
    assign o_param     = r_out.param;
    assign o_status    = r_out.status;

endmodule

`default_nettype wire

@@ sim/tb_command_frame_checker.sv @@
// testbench for the ten-byte command frame checker: framed byte stream against a frame predictor
`timescale 1ns / 100ps

module tb_command_frame_checker
    import cfc_pkg::*;
();

    // longest quiet stretch tolerated before the run is called hung
    localparam int STALL_LIMIT = 5000;
    // length of the deliberate result-side hold-off, in cycles
    localparam int LONG_HOLD   = 300;
    // input words per stimulus phase
    localparam int PHASE_BYTES = 188;

    // ways a generated frame can be spoilt
    typedef enum int {
        F_NONE, F_START, F_VERSION, F_LENGTH, F_CKHI, F_CKLO, F_END, F_SCATTER
    } t_fault;

    // frame predictor and store of expected frame results
    class frame_scoreboard;
        logic [3:0]    pos;
        logic [10:0]   sum;
        logic [2:0]    err;
        logic [7:0]    cmd;
        logic [15:0]   par;
        t_frame_result expected_q[$];
        int            fail_count;
        int            mismatches;
        int            frames_checked;
        int            status_seen[8];

        function new();
            pos = '0;
            sum = '0;
            err = ST_OK;
            cmd = '0;
            par = '0;
            fail_count = 0;
            mismatches = 0;
            frames_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // keep only the first failing check of the frame
        function void flag(bit bad, logic [2:0] code);
            if (bad && err == ST_OK)
                err = code;
        endfunction

        // one accepted byte: advance the frame state, queue a result after byte 9
        function void note_byte(logic [7:0] b);
            logic [15:0]   ck;
            t_frame_result r;
            ck = 16'hFFFF - {5'd0, sum} + 16'd1;
            if (pos >= POS_VERSION && pos <= POS_PARAM_L)
                sum = sum + {3'd0, b};
            ck = 16'hFFFF - {5'd0, sum} + 16'd1;
            case (pos)
                POS_START:   flag(b != FRAME_START, ST_START);
                POS_VERSION: flag(b != FRAME_VERSION, ST_VERSION);
                POS_LENGTH:  flag(b != FRAME_LENGTH, ST_LENGTH);
                POS_COMMAND: cmd = b;
                POS_FEEDBK:  ;
                POS_PARAM_H: par[15:8] = b;
                POS_PARAM_L: par[7:0] = b;
                POS_CK_HI:   flag(b != ck[15:8], ST_CKHI);
                POS_CK_LO:   flag(b != ck[7:0], ST_CKLO);
                default:     flag(b != FRAME_END, ST_END);
            endcase
            if (pos < LAST_POS) begin
                pos = pos + 4'd1;
            end else begin
                r.status  = err;
                r.command = (err == ST_START || err == ST_VERSION || err == ST_LENGTH)
                            ? 8'h00 : cmd;
                r.param   = (err == ST_OK) ? par : 16'h0000;
                expected_q.push_back(r);
                pos = '0;
                sum = '0;
                err = ST_OK;
                cmd = '0;
                par = '0;
            end
        endfunction

        // one accepted result word against the oldest expectation
        function void check_result(t_frame_result got);
            t_frame_result exp_r;
            status_seen[got.status]++;
            if (expected_q.size() == 0) begin
                fail_count++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result cmd=%h param=%h status=%0d",
                             $time, got.command, got.param, got.status);
                return;
            end
            exp_r = expected_q.pop_front();
            frames_checked++;
            if (got.command !== exp_r.command || got.param !== exp_r.param ||
                got.status !== exp_r.status) begin
                fail_count++;
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: frame %0d mismatch exp cmd=%h param=%h status=%0d,",
                              " got cmd=%h param=%h status=%0d"},
                             $time, frames_checked, exp_r.command, exp_r.param,
                             exp_r.status, got.command, got.param, got.status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // clock, reset and block ports; the inputs driven here are known from time zero
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic [7:0]    rx_byte   = 8'h00;
    logic          out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [7:0]    o_command;
    logic [15:0]   o_param;
    logic [2:0]    o_status;

    frame_scoreboard sb = new();
    t_frame_result   got_word;

    // idling knobs, changed only between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // request from the stimulus side for a long result hold-off
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int bytes_sent     = 0;

    command_frame_checker uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_command   (o_command),
        .o_param     (o_param),
        .o_status    (o_status)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: take words at the edge, then choose next cycle's ready
    // the long hold-off is counted here so the sender keeps offering bytes meanwhile
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            got_word.command = o_command;
            got_word.param   = o_param;
            got_word.status  = o_status;
            sb.check_result(got_word);
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hang detection: any word moving on either side restarts the count
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no word moved for %0d cycles, %0d results still expected",
                 STALL_LIMIT, sb.pending());
        $display("tb_command_frame_checker failed");
        $finish;
    end

    // biased byte: the two extremes turn up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // offer one byte, optionally after a random gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!o_in_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // build a frame with a correct checksum, spoil it as asked, send its first nbytes
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] fb,
                              input logic [7:0] ph, input logic [7:0] pl,
                              input t_fault fault, input int nbytes);
        logic [7:0]  fr [10];
        logic [15:0] total;
        int          k;
        fr[0] = FRAME_START;
        fr[1] = FRAME_VERSION;
        fr[2] = FRAME_LENGTH;
        fr[3] = cmd;
        fr[4] = fb;
        fr[5] = ph;
        fr[6] = pl;
        fr[9] = FRAME_END;
        // header faults go in before the checksum so only one check fails
        case (fault)
            F_START:   fr[0] ^= 8'($urandom_range(255, 1));
            F_VERSION: fr[1] ^= 8'($urandom_range(255, 1));
            F_LENGTH:  fr[2] ^= 8'($urandom_range(255, 1));
            default:   ;
        endcase
        total = 16'h0000;
        for (k = 1; k <= 6; k++)
            total += {8'h00, fr[k]};
        total = ~total + 16'd1;
        fr[7] = total[15:8];
        fr[8] = total[7:0];
        case (fault)
            F_CKHI:    fr[7] ^= 8'($urandom_range(255, 1));
            F_CKLO:    fr[8] ^= 8'($urandom_range(255, 1));
            F_END:     fr[9] ^= 8'($urandom_range(255, 1));
            F_SCATTER: begin
                for (k = 0; k < 10; k++)
                    if ($urandom_range(4) == 0)
                        fr[k] = pick_byte();
            end
            default:   ;
        endcase
        for (k = 0; k < nbytes; k++)
            send_byte(fr[k]);
    endtask

    // mostly well-formed frames with random content, some faulty,
    // a few cut short or interleaved with stray bytes so the stream slips
    task automatic run_random(input int target);
        int     r;
        t_fault fault;
        int     nbytes;
        while (bytes_sent < target) begin
            // after a slip, sometimes pad back into step, sometimes carry on misaligned
            if (bytes_sent % 10 != 0 && $urandom_range(1) == 0) begin
                while (bytes_sent % 10 != 0)
                    send_byte(pick_byte());
            end
            if ($urandom_range(19) == 0) begin
                repeat ($urandom_range(3, 1))
                    send_byte(pick_byte());
            end else begin
                r = $urandom_range(99);
                if (r < 55)
                    fault = F_NONE;
                else if (r < 90)
                    fault = t_fault'($urandom_range(6, 1));
                else
                    fault = F_SCATTER;
                nbytes = ($urandom_range(19) == 0) ? $urandom_range(9, 1) : 10;
                send_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           fault, nbytes);
            end
        end
    endtask

    // sender goes quiet until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 0: no idling; directed frames first
        // all-ones and all-zero good frames, then a bad start byte with
        // non-zero command and param, which must both read back as zero
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, F_NONE, 10);
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, F_NONE, 10);
        send_frame(8'hA5, 8'h3C, 8'h12, 8'h34, F_START, 10);
        // long result hold-off while bytes keep coming, so the input backs up
        hold_req = 1'b1;
        run_random(PHASE_BYTES);
        drain();

        // phase 1: sender idles often
        send_idle_pct  = 56;
        recv_stall_pct = 0;
        run_random(2 * PHASE_BYTES);
        drain();

        // phase 2: receiver stalls often
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        run_random(3 * PHASE_BYTES);
        drain();

        // phase 3: both sides idle
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random(4 * PHASE_BYTES);
        drain();

        if (sb.pending() != 0) begin
            sb.fail_count += sb.pending();
            $display("%0d expected results never arrived", sb.pending());
        end

        $display("%0d bytes over four idling phases, %0d frames checked, %0d mismatches",
                 bytes_sent, sb.frames_checked, sb.mismatches);
        $display({"status mix ok/start/version/length/ck-hi/ck-lo/end:",
                  " %0d %0d %0d %0d %0d %0d %0d"},
                 sb.status_seen[ST_OK], sb.status_seen[ST_START],
                 sb.status_seen[ST_VERSION], sb.status_seen[ST_LENGTH],
                 sb.status_seen[ST_CKHI], sb.status_seen[ST_CKLO],
                 sb.status_seen[ST_END]);
        if (sb.fail_count == 0)
            $display("tb_command_frame_checker passed");
        else
            $display("tb_command_frame_checker failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/cfc_pkg.sv
hdl/cfc_frame.sv
hdl/command_frame_checker.sv
sim/tb_command_frame_checker.sv
